>>> hw/rtl/msk_pkg.sv
// ----------------------------------------------------------------------------
// msk_pkg: shared types and constants of the min tracking stack
// Sizes, command and status codes, queue entry and memory word types.
// ----------------------------------------------------------------------------
package msk_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 9;

    localparam int QUEUE_DEPTH = 2;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_PEEK
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [DATA_W-1:0]  value;
    } t_op_entry;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] minimum;
    } t_mem_word;

    typedef enum logic {
        BK_EXEC,
        BK_POP_WAIT
    } t_back_state;

endpackage

>>> hw/rtl/msk_cmd_if.sv
// ----------------------------------------------------------------------------
// msk_cmd_if: command channel
// Valid/ready channel carrying one stack command per transaction.
// ----------------------------------------------------------------------------
interface msk_cmd_if import msk_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic signed [DATA_W-1:0]  push_value;

    modport source (output valid, output command, output push_value, input ready);
    modport sink   (input valid, input command, input push_value, output ready);

endinterface

>>> hw/rtl/msk_rsp_if.sv
// ----------------------------------------------------------------------------
// msk_rsp_if: result channel
// Valid/ready channel carrying the stack state after each command.
// ----------------------------------------------------------------------------
interface msk_rsp_if import msk_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  top_value;
    logic signed [DATA_W-1:0]  minimum_value;
    logic [COUNT_OUT_W-1:0]    entry_count;
    logic                      is_empty;
    logic [STATUS_W-1:0]       status;

    modport source (output valid, output top_value, output minimum_value,
                    output entry_count, output is_empty, output status, input ready);
    modport sink   (input valid, input top_value, input minimum_value,
                    input entry_count, input is_empty, input status, output ready);

endinterface

>>> hw/rtl/msk_front.sv
// ----------------------------------------------------------------------------
// msk_front: command intake
// Accepts command transactions and decodes them into queue operations.
// ----------------------------------------------------------------------------
module msk_front import msk_pkg::*; (
    msk_cmd_if.sink    i_cmd,
    output logic       o_op_valid,
    input  logic       i_op_ready,
    output t_op_entry  o_op
);

    t_op w_op;

    always_comb begin
        case (i_cmd.command)
            CMD_PUSH: w_op = OP_PUSH;
            CMD_POP:  w_op = OP_POP;
            default:  w_op = OP_PEEK;   // unused code behaves as peek
        endcase
    end

    assign o_op_valid = i_cmd.valid;
    assign i_cmd.ready = i_op_ready;
    assign o_op.op    = w_op;
    assign o_op.value = i_cmd.push_value;

endmodule

>>> hw/rtl/msk_queue.sv
// ----------------------------------------------------------------------------
// msk_queue: operation queue
// Short FIFO between the command intake and the stack engine.
// ----------------------------------------------------------------------------
module msk_queue import msk_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_wr_valid,
    output logic       o_wr_ready,
    input  t_op_entry  i_wr_data,
    output logic       o_rd_valid,
    input  logic       i_rd_ready,
    output t_op_entry  o_rd_data
);

    t_op_entry         r_slots [QUEUE_DEPTH];
    logic [QA_W-1:0]   r_wr_ptr;
    logic [QA_W-1:0]   r_rd_ptr;
    logic [QC_W-1:0]   r_fill;
    logic              w_wr;
    logic              w_rd;

    assign o_wr_ready = r_fill != QC_W'(QUEUE_DEPTH);
    assign o_rd_valid = r_fill != '0;
    assign o_rd_data  = r_slots[r_rd_ptr];
    assign w_wr       = i_wr_valid && o_wr_ready;
    assign w_rd       = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + QA_W'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + QA_W'(1);
            end
            if (w_wr && !w_rd) begin
                r_fill <= r_fill + QC_W'(1);
            end else if (w_rd && !w_wr) begin
                r_fill <= r_fill - QC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slots[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

>>> hw/rtl/msk_back.sv
// ----------------------------------------------------------------------------
// msk_back: stack engine
// Executes push, pop and peek against the cached top entry and the entry
// memory, and holds the result transaction in an output register.
// ----------------------------------------------------------------------------
module msk_back import msk_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_op_valid,
    output logic       o_op_ready,
    input  t_op_entry  i_op,
    msk_rsp_if.source  o_rsp
);

    // top entry lives in r_top/r_min; memory holds the entries below it
    t_mem_word            r_mem [STACK_DEPTH];
    t_mem_word            r_rd_data;
    t_back_state          r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [DATA_W-1:0]    r_top, n_top;
    logic [DATA_W-1:0]    r_min, n_min;

    logic                 r_out_valid, n_out_valid;
    logic [DATA_W-1:0]    r_out_top, n_out_top;
    logic [DATA_W-1:0]    r_out_min, n_out_min;
    logic [CNT_W-1:0]     r_out_count, n_out_count;
    t_status              r_out_status, n_out_status;

    logic                 w_out_free;
    logic                 w_take;
    logic                 w_empty;
    logic                 w_full;
    logic [DATA_W-1:0]    w_push_min;
    logic [CNT_W-1:0]     w_wr_idx;
    logic [CNT_W-1:0]     w_rd_idx;
    logic [ADDR_W-1:0]    w_wr_addr;
    logic [ADDR_W-1:0]    w_rd_addr;
    logic                 w_mem_we;

    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign o_op_ready = (r_state == BK_EXEC) && w_out_free;
    assign w_take     = i_op_valid && o_op_ready;
    assign w_empty    = r_count == '0;
    assign w_full     = r_count == CNT_W'(STACK_DEPTH);
    assign w_push_min = (w_empty || ($signed(i_op.value) < $signed(r_min))) ?
                        i_op.value : r_min;
    assign w_wr_idx   = r_count - CNT_W'(1);
    assign w_rd_idx   = r_count - CNT_W'(2);
    assign w_wr_addr  = w_wr_idx[ADDR_W-1:0];
    assign w_rd_addr  = w_rd_idx[ADDR_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_top        = r_top;
        n_min        = r_min;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_top    = r_out_top;
        n_out_min    = r_out_min;
        n_out_count  = r_out_count;
        n_out_status = r_out_status;
        w_mem_we     = 1'b0;
        case (r_state)
            BK_EXEC: begin
                if (w_take) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_count  = r_count;
                    n_out_top    = w_empty ? '0 : r_top;
                    n_out_min    = w_empty ? '0 : r_min;
                    case (i_op.op)
                        OP_PUSH: begin
                            if (w_full) begin
                                n_out_status = ST_OVERFLOW;
                            end else begin
                                w_mem_we    = !w_empty;
                                n_top       = i_op.value;
                                n_min       = w_push_min;
                                n_count     = r_count + CNT_W'(1);
                                n_out_top   = i_op.value;
                                n_out_min   = w_push_min;
                                n_out_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_POP: begin
                            if (w_empty) begin
                                n_out_status = ST_UNDERFLOW;
                            end else if (r_count == CNT_W'(1)) begin
                                n_count     = '0;
                                n_out_count = '0;
                                n_out_top   = '0;
                                n_out_min   = '0;
                            end else begin
                                // new top comes from memory next cycle
                                n_count     = w_wr_idx;
                                n_out_valid = 1'b0;
                                n_state     = BK_POP_WAIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            BK_POP_WAIT: begin
                n_top        = r_rd_data.value;
                n_min        = r_rd_data.minimum;
                n_out_valid  = 1'b1;
                n_out_top    = r_rd_data.value;
                n_out_min    = r_rd_data.minimum;
                n_out_count  = r_count;
                n_out_status = ST_OK;
                n_state      = BK_EXEC;
            end
            default: begin
                n_state = BK_EXEC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_EXEC;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top        <= n_top;
        r_min        <= n_min;
        r_out_top    <= n_out_top;
        r_out_min    <= n_out_min;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_wr_addr] <= '{value: r_top, minimum: r_min};
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.top_value     = r_out_top;
    assign o_rsp.minimum_value = r_out_min;
    assign o_rsp.entry_count   = COUNT_OUT_W'(r_out_count);
    assign o_rsp.is_empty      = r_out_count == '0;
    assign o_rsp.status        = r_out_status;

endmodule

>>> hw/rtl/min_tracking_stack.sv
// ----------------------------------------------------------------------------
// min_tracking_stack: stack of signed 32-bit values with running minimum
// Top level: command intake, operation queue and stack engine.
// ----------------------------------------------------------------------------
// Each command transaction (push, pop, peek) returns one result transaction
// with the top value, the minimum of all held values, the entry count, an
// empty flag and a status (pop on empty or push on full are ignored and
// flagged). Depth is STACK_DEPTH entries. Push, peek and pops that leave the
// stack empty complete in the BK_EXEC state of the stack engine; any other pop
// also passes through the BK_POP_WAIT state, because the new top entry comes
// from the registered read port of the entry memory. A two-entry queue between
// intake and engine absorbs commands while the engine is busy or a result
// waits to be taken. No clearing pass after reset.
module min_tracking_stack import msk_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    msk_cmd_if.sink    i_cmd,
    msk_rsp_if.source  o_rsp
);

    logic       w_q_wr_valid;
    logic       w_q_wr_ready;
    t_op_entry  w_q_wr_data;
    logic       w_q_rd_valid;
    logic       w_q_rd_ready;
    t_op_entry  w_q_rd_data;

    msk_front u_front (
        .i_cmd      (i_cmd),
        .o_op_valid (w_q_wr_valid),
        .i_op_ready (w_q_wr_ready),
        .o_op       (w_q_wr_data)
    );

    msk_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_q_wr_valid),
        .o_wr_ready (w_q_wr_ready),
        .i_wr_data  (w_q_wr_data),
        .o_rd_valid (w_q_rd_valid),
        .i_rd_ready (w_q_rd_ready),
        .o_rd_data  (w_q_rd_data)
    );

    msk_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (w_q_rd_valid),
        .o_op_ready (w_q_rd_ready),
        .i_op       (w_q_rd_data),
        .o_rsp      (o_rsp)
    );

`ifndef SYNTHESIS
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.status == ST_OVERFLOW)
        |-> o_rsp.entry_count == COUNT_OUT_W'(STACK_DEPTH))
        else $error("overflow reported on a stack that is not full");

    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.status == ST_UNDERFLOW)
        |-> o_rsp.is_empty && (o_rsp.top_value == '0) && (o_rsp.minimum_value == '0))
        else $error("underflow reported on a stack that is not empty");

    a_queue_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_rd_valid && w_q_rd_ready && !(w_q_wr_valid && w_q_wr_ready)
        |=> w_q_wr_ready)
        else $error("queue still full after an entry was drained");
`endif

endmodule
